@@ sv/assert_macros.svh @@
// Assertion shorthands for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ sv/mscf_pkg.sv @@
`default_nettype none
package mscf_pkg;

    localparam int MOTORS        = 4;
    localparam int SETPOINT_BITS = 16;
    localparam int FRAC_BITS     = SETPOINT_BITS - 1;
    localparam int MOTOR_IDX_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int NODE_REGS     = 4;

    localparam int MODE_W    = 2;
    localparam int STEP_W    = 16;
    localparam int SCALE_W   = 24;
    localparam int NODE_W    = 9;
    localparam int TARGET_W  = 16;
    localparam int OUT_IDX_W = 2;
    localparam int ID_W      = 29;
    localparam int PAYLOAD_W = 32;
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;

    localparam int MAG_W  = FRAC_BITS;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int RAMP_W = ((SETPOINT_BITS > STEP_W) ? SETPOINT_BITS : STEP_W) + 2;

    localparam int FIFO_DEPTH = 2 * MOTORS;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef logic signed [SETPOINT_BITS-1:0] t_sp;

    localparam logic signed [31:0] FULL_SCALE = 32'((1 << FRAC_BITS) - 1);

    typedef enum logic [2:0] {
        REG_MODE,
        REG_STEP,
        REG_SCALE,
        REG_NODE0,
        REG_NODE1,
        REG_NODE2,
        REG_NODE3
    } t_reg_idx;

    localparam logic [MODE_W-1:0] MODE_DUTY    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERPM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURRENT = 2'd2;

    localparam logic [CMD_W-1:0] CMD_DUTY    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CURRENT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERPM    = 2'd3;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_SWEEP
    } t_seq;

    typedef struct packed {
        logic [MODE_W-1:0]                   drive_mode;
        logic [STEP_W-1:0]                   step_limit;
        logic [SCALE_W-1:0]                  command_scale;
        logic [NODE_REGS-1:0][NODE_W-1:0]    node_id;
    } t_cfg;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]        motor_index;
        logic [ID_W-1:0]             frame_id;
        logic signed [PAYLOAD_W-1:0] payload;
        logic                        last;
    } t_frame;

    function automatic logic [CMD_W-1:0] mode_code(input logic [MODE_W-1:0] mode);
        logic [CMD_W-1:0] code;
        case (mode)
            MODE_ERPM:    code = CMD_ERPM;
            MODE_CURRENT: code = CMD_CURRENT;
            default:      code = CMD_DUTY;
        endcase
        return code;
    endfunction

    function automatic logic node_en(input t_cfg cfg, input logic [MOTOR_IDX_W-1:0] idx);
        logic en;
        en = 1'b0;
        for (int i = 0; i < NODE_REGS; i++) begin
            if (int'(idx) == i) begin
                en = !cfg.node_id[i][NODE_W-1];
            end
        end
        return en;
    endfunction

    function automatic logic [BYTE_W-1:0] node_byte(input t_cfg cfg,
                                                    input logic [MOTOR_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int i = 0; i < NODE_REGS; i++) begin
            if (int'(idx) == i) begin
                b = cfg.node_id[i][BYTE_W-1:0];
            end
        end
        return b;
    endfunction

    // no enabled node above idx
    function automatic logic frame_last(input t_cfg cfg, input logic [MOTOR_IDX_W-1:0] idx);
        logic lst;
        lst = 1'b1;
        for (int i = 0; i < NODE_REGS; i++) begin
            if (i > int'(idx) && i < MOTORS && !cfg.node_id[i][NODE_W-1]) begin
                lst = 1'b0;
            end
        end
        return lst;
    endfunction

endpackage
`default_nettype wire

@@ sv/motor_setpoint_ramp_can_framer_unit.sv @@
// Slew-rate limited setpoints and command framing for four motors. A store beat (op 0)
// saturates its target to +/- full scale and writes the target memory and gives no frame.
// A tick beat (op 1) sweeps the motors in order, one memory read per cycle, and each
// motor then passes a ramp stage (setpoint write-back), a multiply stage and a framing
// stage, so a tick holds the input until its last motor has left the framing stage.
// Frames of enabled nodes land in an 8-deep output queue; input ready also needs room
// there for a full tick (at most 4 frames pending). Targets and setpoints reset to zero
// through per-entry valid bits, so no clearing pass follows reset. Registers sit at byte
// addresses 4*i on the APB port.
`default_nettype none
module motor_setpoint_ramp_can_framer_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mscf_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [mscf_pkg::PDATA_W-1:0]         pwdata,
    output logic      [mscf_pkg::PDATA_W-1:0]         prdata,
    output logic                                      pready,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_op,
    input  wire logic [1:0]                           i_motor,
    input  wire logic signed [mscf_pkg::TARGET_W-1:0] i_target,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [mscf_pkg::OUT_IDX_W-1:0]            o_motor_index,
    output logic [mscf_pkg::ID_W-1:0]                 o_frame_id,
    output logic signed [mscf_pkg::PAYLOAD_W-1:0]     o_payload,
    output logic                                      o_last
);
    import mscf_pkg::*;

    t_cfg                  w_cfg;
    logic                  w_push;
    t_frame                w_frame_in;
    t_frame                w_frame_out;
    logic [FIFO_CNT_W-1:0] w_cnt;

    mscf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mscf_ramp u_ramp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_motor    (i_motor),
        .i_target   (i_target),
        .i_cfg      (w_cfg),
        .i_fifo_cnt (w_cnt),
        .o_push     (w_push),
        .o_frame    (w_frame_in)
    );

    mscf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_frame_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_frame (w_frame_out),
        .o_cnt   (w_cnt)
    );

    assign o_motor_index = w_frame_out.motor_index;
    assign o_frame_id    = w_frame_out.frame_id;
    assign o_payload     = w_frame_out.payload;
    assign o_last        = w_frame_out.last;

endmodule
`default_nettype wire

@@ sv/mscf_ram.sv @@
`default_nettype none
module mscf_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/mscf_cfg.sv @@
`default_nettype none
module mscf_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mscf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mscf_pkg::PDATA_W-1:0] pwdata,
    output logic      [mscf_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output mscf_pkg::t_cfg                    o_cfg
);
    import mscf_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_MODE:  n_cfg.drive_mode    = pwdata[MODE_W-1:0];
                REG_STEP:  n_cfg.step_limit    = pwdata[STEP_W-1:0];
                REG_SCALE: n_cfg.command_scale = pwdata[SCALE_W-1:0];
                REG_NODE0: n_cfg.node_id[0]    = pwdata[NODE_W-1:0];
                REG_NODE1: n_cfg.node_id[1]    = pwdata[NODE_W-1:0];
                REG_NODE2: n_cfg.node_id[2]    = pwdata[NODE_W-1:0];
                REG_NODE3: n_cfg.node_id[3]    = pwdata[NODE_W-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_mode    <= MODE_DUTY;
            r_cfg.step_limit    <= 16'd3277;
            r_cfg.command_scale <= 24'd35000;
            r_cfg.node_id[0]    <= 9'd53;
            r_cfg.node_id[1]    <= 9'd44;
            r_cfg.node_id[2]    <= '1;
            r_cfg.node_id[3]    <= '1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:  prdata = {{(PDATA_W-MODE_W){1'b0}}, r_cfg.drive_mode};
            REG_STEP:  prdata = {{(PDATA_W-STEP_W){1'b0}}, r_cfg.step_limit};
            REG_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, r_cfg.command_scale};
            REG_NODE0: prdata = {{(PDATA_W-NODE_W){r_cfg.node_id[0][NODE_W-1]}},
                                 r_cfg.node_id[0]};
            REG_NODE1: prdata = {{(PDATA_W-NODE_W){r_cfg.node_id[1][NODE_W-1]}},
                                 r_cfg.node_id[1]};
            REG_NODE2: prdata = {{(PDATA_W-NODE_W){r_cfg.node_id[2][NODE_W-1]}},
                                 r_cfg.node_id[2]};
            REG_NODE3: prdata = {{(PDATA_W-NODE_W){r_cfg.node_id[3][NODE_W-1]}},
                                 r_cfg.node_id[3]};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ sv/mscf_ramp.sv @@
`default_nettype none
module mscf_ramp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_op,
    input  wire logic [1:0]                           i_motor,
    input  wire logic signed [mscf_pkg::TARGET_W-1:0] i_target,
    input  mscf_pkg::t_cfg                            i_cfg,
    input  wire logic [mscf_pkg::FIFO_CNT_W-1:0]      i_fifo_cnt,
    output logic                                      o_push,
    output mscf_pkg::t_frame                          o_frame
);
    import mscf_pkg::*;

    t_seq                     r_state;
    t_seq                     n_state;
    logic [MOTOR_IDX_W-1:0]   r_addr;
    logic [MOTOR_IDX_W-1:0]   n_addr;

    logic                     r_s1_vld;
    logic [MOTOR_IDX_W-1:0]   r_s1_idx;
    logic                     r_s2_vld;
    logic [MOTOR_IDX_W-1:0]   r_s2_idx;
    t_sp                      r_s2_sp;
    logic                     r_s3_vld;
    logic [MOTOR_IDX_W-1:0]   r_s3_idx;
    logic                     r_s3_neg;
    logic [PROD_W-1:0]        r_s3_prod;

    logic                     w_acc;
    logic                     w_busy;
    logic                     w_tgt_we;
    logic signed [31:0]       w_tgt_ext;
    logic signed [31:0]       w_tgt_clamp;
    t_sp                      w_tgt_sat;
    t_sp                      w_cur;
    t_sp                      w_tgt;
    logic signed [RAMP_W-1:0] w_cur_x;
    logic signed [RAMP_W-1:0] w_tgt_x;
    logic signed [RAMP_W-1:0] w_step_x;
    logic signed [RAMP_W-1:0] w_sum;
    logic signed [RAMP_W-1:0] w_new_x;
    t_sp                      w_new;
    logic [MAG_W-1:0]         w_mag;
    logic [SCALE_W-1:0]       w_q;
    logic [PAYLOAD_W-1:0]     w_q_ext;

    assign w_busy  = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_ready = (r_state == SEQ_IDLE) && !w_busy
                     && (i_fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - MOTORS));
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            SEQ_IDLE: begin
                if (w_acc && i_op) begin
                    n_state = SEQ_SWEEP;
                    n_addr  = '0;
                end
            end
            SEQ_SWEEP: begin
                if (r_addr == MOTOR_IDX_W'(MOTORS - 1)) begin
                    n_state = SEQ_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // target store path
    assign w_tgt_ext = {{(32-TARGET_W){i_target[TARGET_W-1]}}, i_target};
    always_comb begin
        if (w_tgt_ext > FULL_SCALE) begin
            w_tgt_clamp = FULL_SCALE;
        end else if (w_tgt_ext < -FULL_SCALE) begin
            w_tgt_clamp = -FULL_SCALE;
        end else begin
            w_tgt_clamp = w_tgt_ext;
        end
    end
    assign w_tgt_sat = t_sp'(w_tgt_clamp[SETPOINT_BITS-1:0]);
    assign w_tgt_we  = w_acc && !i_op && (int'(i_motor) < MOTORS);

    mscf_ram #(.DEPTH(MOTORS), .WIDTH(SETPOINT_BITS)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_tgt_we),
        .i_waddr (MOTOR_IDX_W'(i_motor)),
        .i_wdata (w_tgt_sat),
        .i_raddr (r_addr),
        .o_rdata (w_tgt)
    );

    mscf_ram #(.DEPTH(MOTORS), .WIDTH(SETPOINT_BITS)) u_sp_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_idx),
        .i_wdata (w_new),
        .i_raddr (r_addr),
        .o_rdata (w_cur)
    );

    // ramp toward target, no overshoot
    assign w_cur_x  = RAMP_W'(w_cur);
    assign w_tgt_x  = RAMP_W'(w_tgt);
    assign w_step_x = $signed({{(RAMP_W-STEP_W){1'b0}}, i_cfg.step_limit});

    always_comb begin
        if (w_cur_x < w_tgt_x) begin
            w_sum   = w_cur_x + w_step_x;
            w_new_x = (w_sum < w_tgt_x) ? w_sum : w_tgt_x;
        end else if (w_cur_x > w_tgt_x) begin
            w_sum   = w_cur_x - w_step_x;
            w_new_x = (w_sum > w_tgt_x) ? w_sum : w_tgt_x;
        end else begin
            w_sum   = w_cur_x;
            w_new_x = w_cur_x;
        end
    end
    assign w_new = t_sp'(w_new_x[SETPOINT_BITS-1:0]);

    assign w_mag = r_s2_sp[SETPOINT_BITS-1] ? MAG_W'(-r_s2_sp) : MAG_W'(r_s2_sp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == SEQ_SWEEP);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_addr;
        r_s2_idx  <= r_s1_idx;
        r_s2_sp   <= w_new;
        r_s3_idx  <= r_s2_idx;
        r_s3_neg  <= r_s2_sp[SETPOINT_BITS-1];
        r_s3_prod <= PROD_W'(w_mag) * PROD_W'(i_cfg.command_scale);
    end

    // shift out fraction, reapply sign (truncates toward zero)
    assign w_q     = r_s3_prod[PROD_W-1:FRAC_BITS];
    assign w_q_ext = {{(PAYLOAD_W-SCALE_W){1'b0}}, w_q};

    assign o_push = r_s3_vld && node_en(i_cfg, r_s3_idx);

    always_comb begin
        o_frame.motor_index = OUT_IDX_W'(r_s3_idx);
        o_frame.frame_id    = {{(ID_W-CMD_W-BYTE_W){1'b0}},
                               mode_code(i_cfg.drive_mode),
                               node_byte(i_cfg, r_s3_idx)};
        o_frame.payload     = r_s3_neg ? $signed(-w_q_ext) : $signed(w_q_ext);
        o_frame.last        = frame_last(i_cfg, r_s3_idx);
    end

endmodule
`default_nettype wire

@@ sv/mscf_fifo.sv @@
`default_nettype none
module mscf_fifo (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  mscf_pkg::t_frame                     i_frame,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output mscf_pkg::t_frame                     o_frame,
    output logic [mscf_pkg::FIFO_CNT_W-1:0]      o_cnt
);
    import mscf_pkg::*;

    t_frame                r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_frame = r_buf[r_rptr];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/mscf_chk.sv @@
`default_nettype none
`include "assert_macros.svh"
module mscf_chk (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_ready,
    input wire logic                                 i_op,
    input wire logic                                 o_valid,
    input wire logic                                 i_ready,
    input wire logic signed [mscf_pkg::PAYLOAD_W-1:0] o_payload
);

    // a tick beat starts the sweep, input closes
    `AST_NEXT(a_tick_closes_input, i_clk, i_rst_n, i_valid && o_ready && i_op, !o_ready)

    // a store beat never blocks the next beat
    `AST_NEXT(a_store_keeps_ready, i_clk, i_rst_n, i_valid && o_ready && !i_op, o_ready)

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_payload))

endmodule

bind motor_setpoint_ramp_can_framer_unit mscf_chk u_mscf_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .i_op      (i_op),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_payload (o_payload)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mscf_pkg::*;

    localparam logic             OP_STORE      = 1'b0;
    localparam logic             OP_TICK       = 1'b1;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
    localparam int               SETTLE_CYCLES = 24;
    localparam int               STALL_LIMIT   = 2000;
    localparam int               HOLD_CYCLES   = 300;
    localparam int               PHASES        = 8;
    localparam int               PHASE_ITEMS   = 45;
    localparam int               ROWS          = 37;
    localparam int               GOLDS         = 6;

    typedef struct packed {
        logic        is_cfg;
        t_reg_idx    reg_idx;
        logic [31:0] value;
        logic        op;
        logic [1:0]  motor;
        logic [15:0] target;
    } t_row;

    typedef struct packed {
        logic [7:0] row;
        t_frame     frame;
    } t_gold;

    localparam t_row DIR_ROWS [ROWS] = '{
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd0, 16'h7FFF},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd1, 16'h8000},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd2, 16'h0064},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd3, 16'hFF9C},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd3, 16'hFFFF},
        '{1'b1, REG_STEP,  32'd65535,    OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_SCALE, 32'd32768,    OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_NODE2, 32'h0FF,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_NODE3, 32'h000,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_MODE,  32'(MODE_ERPM), OP_STORE, 2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd1, 16'h1234},
        '{1'b1, REG_MODE,  32'(MODE_CURRENT), OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_STEP,  32'd0,        OP_STORE, 2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd0, 16'h8000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b1, REG_NODE0, 32'h1FE,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_MODE,  32'(MODE_SPARE), OP_STORE, 2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd2, 16'h8000},
        '{1'b1, REG_NODE1, 32'h1FF,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_NODE2, 32'h100,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_NODE3, 32'h1FF,      OP_STORE, 2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b1, REG_SCALE, 32'hFFFFFF,   OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_STEP,  32'd1,        OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_NODE0, 32'h000,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_NODE1, 32'h080,      OP_STORE, 2'd0, 16'h0000},
        '{1'b1, REG_MODE,  32'(MODE_DUTY), OP_STORE, 2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd1, 16'h7FFF},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd2, 16'hFFFF},
        '{1'b0, REG_MODE,  32'd0,        OP_STORE, 2'd3, 16'h8001},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b1, REG_STEP,  32'h7FFF,     OP_STORE, 2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000},
        '{1'b0, REG_MODE,  32'd0,        OP_TICK,  2'd0, 16'h0000}
    };

    // scale 32768 makes the payload equal to the setpoint
    localparam t_gold GOLD_FRAMES [GOLDS] = '{
        '{8'd0,  '{2'd0, 29'h035, 32'sd0,       1'b0}},
        '{8'd0,  '{2'd1, 29'h02C, 32'sd0,       1'b1}},
        '{8'd12, '{2'd0, 29'h335, 32'sd32767,   1'b0}},
        '{8'd12, '{2'd1, 29'h32C, -32'sd32767,  1'b0}},
        '{8'd12, '{2'd2, 29'h3FF, 32'sd100,     1'b0}},
        '{8'd12, '{2'd3, 29'h300, -32'sd100,    1'b1}}
    };

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [PADDR_W-1:0]          paddr    = '0;
    logic [PDATA_W-1:0]          pwdata   = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        i_valid  = 1'b0;
    logic                        o_ready;
    logic                        i_op     = 1'b0;
    logic [1:0]                  i_motor  = '0;
    logic signed [TARGET_W-1:0]  i_target = '0;
    logic                        o_valid;
    logic                        i_ready  = 1'b0;
    logic [OUT_IDX_W-1:0]        o_motor_index;
    logic [ID_W-1:0]             o_frame_id;
    logic signed [PAYLOAD_W-1:0] o_payload;
    logic                        o_last;

    logic [MODE_W-1:0]               cfg_mode;
    logic [STEP_W-1:0]               cfg_step;
    logic [SCALE_W-1:0]              cfg_scale;
    logic signed [NODE_W-1:0]        cfg_node [NODE_REGS];
    logic signed [SETPOINT_BITS-1:0] target_mem [MOTORS];
    logic signed [SETPOINT_BITS-1:0] setpoint_mem [MOTORS];

    t_frame pending_frames [$];
    int     fail_count  = 0;
    bit     idle_on     = 1'b1;
    logic   hold_req    = 1'b0;
    int     hold_left   = 0;
    bit     hold_done   = 1'b0;
    int     quiet_count = 0;

    motor_setpoint_ramp_can_framer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_motor       (i_motor),
        .i_target      (i_target),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_motor_index (o_motor_index),
        .o_frame_id    (o_frame_id),
        .o_payload     (o_payload),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    // store saturates; tick ramps every motor, then frames the enabled ones in order
    task automatic ramp_and_frame(input logic op, input logic [1:0] m,
                                  input logic signed [TARGET_W-1:0] t, input bit keep);
        int               cur;
        int               goal;
        int               nxt;
        int               last_idx;
        longint           mag;
        longint           q;
        logic [CMD_W-1:0] code;
        t_frame           fr;
        if (op == OP_STORE) begin
            goal = int'(t);
            if (goal > FULL_SCALE) goal = FULL_SCALE;
            if (goal < -FULL_SCALE) goal = -FULL_SCALE;
            if (int'(m) < MOTORS) target_mem[m] = goal[SETPOINT_BITS-1:0];
        end else begin
            for (int i = 0; i < MOTORS; i++) begin
                cur  = int'(setpoint_mem[i]);
                goal = int'(target_mem[i]);
                if (cur < goal) begin
                    nxt = cur + int'(cfg_step);
                    cur = (nxt < goal) ? nxt : goal;
                end else if (cur > goal) begin
                    nxt = cur - int'(cfg_step);
                    cur = (nxt > goal) ? nxt : goal;
                end
                setpoint_mem[i] = cur[SETPOINT_BITS-1:0];
            end
            code = (cfg_mode == MODE_ERPM) ? CMD_ERPM :
                   (cfg_mode == MODE_CURRENT) ? CMD_CURRENT : CMD_DUTY;
            last_idx = -1;
            for (int i = 0; i < MOTORS && i < NODE_REGS; i++) begin
                if (!cfg_node[i][NODE_W-1]) last_idx = i;
            end
            for (int i = 0; i < MOTORS && i < NODE_REGS; i++) begin
                if (!cfg_node[i][NODE_W-1]) begin
                    mag = (setpoint_mem[i] < 0) ? -longint'(setpoint_mem[i])
                                                : longint'(setpoint_mem[i]);
                    q = (mag * longint'(cfg_scale)) >>> FRAC_BITS;
                    if (setpoint_mem[i] < 0 && q > 64'sd2147483648) q = 64'sd2147483648;
                    if (setpoint_mem[i] >= 0 && q > 64'sd2147483647) q = 64'sd2147483647;
                    fr.motor_index = OUT_IDX_W'(i);
                    fr.frame_id    = ID_W'({code, cfg_node[i][BYTE_W-1:0]});
                    fr.payload     = (setpoint_mem[i] < 0) ? PAYLOAD_W'(-q) : PAYLOAD_W'(q);
                    fr.last        = (i == last_idx);
                    if (keep) pending_frames.push_back(fr);
                end
            end
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:  cfg_mode  = value[MODE_W-1:0];
            REG_STEP:  cfg_step  = value[STEP_W-1:0];
            REG_SCALE: cfg_scale = value[SCALE_W-1:0];
            default:   cfg_node[int'(idx) - int'(REG_NODE0)] = value[NODE_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_and_wait();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input logic op, input logic [1:0] m,
                             input logic signed [TARGET_W-1:0] t, input bit keep);
        if (idle_on && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_motor  <= m;
        i_target <= t;
        do @(posedge i_clk); while (!o_ready);
        ramp_and_frame(op, m, t, keep);
    endtask

    always @(posedge i_clk) begin : frame_sink
        t_frame want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_frames.size() == 0) begin
                    $display("%0t: unexpected frame motor %0d id %h payload %0d last %0b",
                             $realtime, o_motor_index, o_frame_id, o_payload, o_last);
                    fail_count++;
                end else begin
                    want = pending_frames.pop_front();
                    if (o_motor_index !== want.motor_index) begin
                        $display("%0t: motor_index expected %0d got %0d",
                                 $realtime, want.motor_index, o_motor_index);
                        fail_count++;
                    end
                    if (o_frame_id !== want.frame_id) begin
                        $display("%0t: frame_id expected %h got %h",
                                 $realtime, want.frame_id, o_frame_id);
                        fail_count++;
                    end
                    if (o_payload !== want.payload) begin
                        $display("%0t: payload expected %0d got %0d",
                                 $realtime, want.payload, o_payload);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0b got %0b",
                                 $realtime, want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= STALL_LIMIT) begin
            $display("[motor_setpoint_ramp_can_framer_unit] ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0]                vals [7];
        logic                       op;
        logic [1:0]                 m;
        logic signed [TARGET_W-1:0] t;
        int                         pick;
        bit                         has_gold;
        bit                         busy;
        cfg_mode    = MODE_DUTY;
        cfg_step    = 16'd3277;
        cfg_scale   = 24'd35000;
        cfg_node[0] = 9'sd53;
        cfg_node[1] = 9'sd44;
        cfg_node[2] = -9'sd1;
        cfg_node[3] = -9'sd1;
        for (int i = 0; i < MOTORS; i++) begin
            target_mem[i]   = '0;
            setpoint_mem[i] = '0;
        end
        busy = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++) begin
            if (DIR_ROWS[r].is_cfg) begin
                if (busy) drain_and_wait();
                busy = 1'b0;
                write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].value);
            end else begin
                has_gold = 1'b0;
                for (int g = 0; g < GOLDS; g++) begin
                    if (int'(GOLD_FRAMES[g].row) == r) begin
                        pending_frames.push_back(GOLD_FRAMES[g].frame);
                        has_gold = 1'b1;
                    end
                end
                send_item(DIR_ROWS[r].op, DIR_ROWS[r].motor, DIR_ROWS[r].target, !has_gold);
                busy = 1'b1;
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_and_wait();
            if (ph == 0) begin
                vals[0] = 32'(MODE_CURRENT);
                vals[1] = 32'hFFFF;
                vals[2] = 32'hFFFFFF;
                for (int k = 0; k < NODE_REGS; k++) vals[3+k] = 32'h0FF;
            end else if (ph == 1) begin
                vals[0] = 32'(MODE_DUTY);
                vals[1] = 32'd0;
                vals[2] = 32'd0;
                for (int k = 0; k < NODE_REGS; k++) vals[3+k] = 32'h000;
            end else begin
                vals[0] = 32'(2'($urandom));
                pick = $urandom_range(9);
                vals[1] = (pick == 0) ? 32'hFFFF : (pick == 1) ? 32'd1 :
                          (pick < 4) ? 32'(16'($urandom)) : 32'($urandom_range(12000, 50));
                pick = $urandom_range(9);
                vals[2] = (pick == 0) ? 32'hFFFFFF : (pick == 1) ? 32'd32768 :
                          32'(24'($urandom));
                for (int k = 0; k < NODE_REGS; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 20) begin
                        vals[3+k] = 32'h1FF;
                    end else if (pick < 30) begin
                        vals[3+k] = {23'd0, 1'b1, 8'($urandom)};
                    end else begin
                        vals[3+k] = {24'd0, 8'($urandom)};
                    end
                end
            end
            for (int k = 0; k < 7; k++) write_reg(t_reg_idx'(k), vals[k]);
            idle_on = (ph != 2);
            if (ph == 4) hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(99) < 35) ? OP_TICK : OP_STORE;
                m  = 2'($urandom);
                case ($urandom_range(11))
                    0:       t = 16'sh8000;
                    1:       t = 16'sh7FFF;
                    2:       t = 16'sh8001;
                    3:       t = 16'sh0000;
                    default: t = 16'($urandom);
                endcase
                send_item(op, m, t, 1'b1);
            end
        end

        drain_and_wait();
        if (fail_count == 0) begin
            $display("[motor_setpoint_ramp_can_framer_unit] OK");
        end else begin
            $display("[motor_setpoint_ramp_can_framer_unit] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
